// ===== rtl/ubx_frame_receiver_assert.svh =====
// ---------------------------------------------------------------------------
// UBX frame receiver assertion macros
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define UBX_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define UBX_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define UBX_ASSERT_NOW(label, clk, rst, cond, prop, msg)

`define UBX_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// ===== rtl/ubx_pkg.sv =====
// ---------------------------------------------------------------------------
// UBX frame receiver package
// Shared types, codes and constants of the frame receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubx_pkg;

  // Sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_CLASS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_ID     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANT_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 2'd3;

  localparam logic [7:0]  RST_WANT_CLASS  = 8'h01;
  localparam logic [7:0]  RST_WANT_ID     = 8'h07;
  localparam logic [15:0] RST_WANT_LENGTH = 16'd92;
  localparam logic [15:0] RST_MAX_LENGTH  = 16'd96;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHECK_A = 4'd7,
    PH_CHECK_B = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD        = 2'd0,
    ST_CHECK_A_BAD = 2'd1,
    ST_CHECK_B_BAD = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]  want_class;
    logic [7:0]  want_id;
    logic [15:0] want_length;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  hdr_class;
    logic [7:0]  hdr_id;
    logic [15:0] frame_length;
    status_t     status;
    logic        wanted;
  } result_t;

endpackage

// ===== rtl/ubx_frame_receiver.sv =====
// One received byte is taken per clock cycle when in_stall is low; the byte
// is parsed in the cycle it is accepted and its result, if any, is registered
// into the output register, or into the skid entry while that one is held. A
// two-entry output (an output register and a skid entry) keeps input
// accepting while one result waits downstream; in_stall rises only when both
// entries hold results. Configuration registers are written through wr_en,
// wr_index and wr_data and take effect on the next accepted byte.
// ---------------------------------------------------------------------------
// UBX frame receiver top level
// Sync hunt, header decode, Fletcher-8 check and payload byte streaming.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ubx_frame_receiver_assert.svh"

module ubx_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ubx_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [ubx_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [7:0]                       data_byte,
  output logic [15:0]                      byte_index,
  output logic [7:0]                       hdr_class,
  output logic [7:0]                       hdr_id,
  output logic [15:0]                      frame_length,
  output logic [1:0]                       status,
  output logic                             wanted
);
  import ubx_pkg::*;

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_byte;
  logic    index_ok;
  logic    good_end;

  assign in_accept = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.want_class  <= RST_WANT_CLASS;
      cfg.want_id     <= RST_WANT_ID;
      cfg.want_length <= RST_WANT_LENGTH;
      cfg.max_length  <= RST_MAX_LENGTH;
    end else if (wr_en) begin
      case (wr_index)
        CFG_WANT_CLASS:  cfg.want_class  <= wr_data[7:0];
        CFG_WANT_ID:     cfg.want_id     <= wr_data[7:0];
        CFG_WANT_LENGTH: cfg.want_length <= wr_data;
        CFG_MAX_LENGTH:  cfg.max_length  <= wr_data;
        default: ;
      endcase
    end
  end

  ubx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ubx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result onto the ports
  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign byte_index   = out_res.byte_index;
  assign hdr_class    = out_res.hdr_class;
  assign hdr_id       = out_res.hdr_id;
  assign frame_length = out_res.frame_length;
  assign status       = out_res.status;
  assign wanted       = out_res.wanted;

  // Terms for the checks below
  assign out_byte = out_valid && (kind == KIND_BYTE);
  assign index_ok = byte_index < frame_length;
  assign good_end = (kind == KIND_END) && (status == ST_GOOD);

  // Skid entry only fills behind a held output
  `UBX_ASSERT_NOW(a_skid_behind_out, clk, rst, in_stall, out_valid, "skid full, output empty")

  // Payload byte index stays inside the announced length
  `UBX_ASSERT_NOW(a_index_in_range, clk, rst, out_byte, index_ok, "index beyond length")

  // A wanted flag only comes with a good frame end
  `UBX_ASSERT_NOW(a_wanted_good_end, clk, rst, out_valid && wanted, good_end, "wanted not good")

  // A full buffer that is not drained keeps stalling input
  `UBX_ASSERT_NEXT(a_stall_held, clk, rst, in_stall && out_stall, in_stall, "stall dropped")

endmodule

// ===== rtl/ubx_parser.sv =====
// ---------------------------------------------------------------------------
// UBX frame parser
// Per-byte frame state machine with running Fletcher-8 sums; one result
// request at most per accepted byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubx_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [7:0]       rx_byte,
  input  ubx_pkg::cfg_t    cfg,
  output logic             res_valid,
  output ubx_pkg::result_t res
);
  import ubx_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [16:0] idx_plus;

  // Fletcher step and length helpers
  assign add_a    = sum_a + rx_byte;
  assign add_b    = sum_b + add_a;
  assign len_full = {rx_byte, cur_length[7:0]};
  assign idx_plus = {1'b0, payload_count} + 17'd1;

  // Hold state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      cur_class     <= '0;
      cur_id        <= '0;
      cur_length    <= '0;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
    end else begin
      phase         <= phase_next;
      cur_class     <= cur_class_next;
      cur_id        <= cur_id_next;
      cur_length    <= cur_length_next;
      payload_count <= payload_count_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
    end
  end

  // Next state and result request
  always_comb begin
    phase_next         = phase;
    cur_class_next     = cur_class;
    cur_id_next        = cur_id;
    cur_length_next    = cur_length;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    res_valid          = 1'b0;
    res.kind           = KIND_END;
    res.data_byte      = '0;
    res.byte_index     = '0;
    res.status         = ST_GOOD;
    res.wanted         = 1'b0;

    if (in_accept) begin
      case (phase)
        PH_SYNC2: begin
          phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
        end
        PH_CLASS: begin
          cur_class_next = rx_byte;
          sum_a_next     = rx_byte;
          sum_b_next     = rx_byte;
          phase_next     = PH_ID;
        end
        PH_ID: begin
          cur_id_next = rx_byte;
          sum_a_next  = add_a;
          sum_b_next  = add_b;
          phase_next  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cur_length_next = {8'h00, rx_byte};
          sum_a_next      = add_a;
          sum_b_next      = add_b;
          phase_next      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cur_length_next    = len_full;
          sum_a_next         = add_a;
          sum_b_next         = add_b;
          payload_count_next = '0;
          if (len_full == 16'd0) begin
            phase_next = PH_CHECK_A;
          end else if (len_full > cfg.max_length) begin
            // drop an oversize frame right away
            phase_next = PH_SYNC1;
            res_valid  = 1'b1;
            res.status = ST_TOO_LONG;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_next         = add_a;
          sum_b_next         = add_b;
          payload_count_next = idx_plus[15:0];
          if (idx_plus >= {1'b0, cur_length}) begin
            phase_next = PH_CHECK_A;
          end
          res_valid      = 1'b1;
          res.kind       = KIND_BYTE;
          res.data_byte  = rx_byte;
          res.byte_index = payload_count;
        end
        PH_CHECK_A: begin
          if (rx_byte == sum_a) begin
            phase_next = PH_CHECK_B;
          end else begin
            phase_next = PH_SYNC1;
            res_valid  = 1'b1;
            res.status = ST_CHECK_A_BAD;
          end
        end
        PH_CHECK_B: begin
          phase_next = PH_SYNC1;
          res_valid  = 1'b1;
          if (rx_byte != sum_b) begin
            res.status = ST_CHECK_B_BAD;
          end else begin
            res.wanted = (cur_class == cfg.want_class) && (cur_id == cfg.want_id) &&
                         (cur_length == cfg.want_length);
          end
        end
        default: begin
          // hunt for the first sync byte; unused codes land here too
          phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end

    res.hdr_class    = cur_class_next;
    res.hdr_id       = cur_id_next;
    res.frame_length = cur_length_next;
  end

endmodule

// ===== rtl/ubx_out_buf.sv =====
// ---------------------------------------------------------------------------
// UBX result output buffer
// Output register plus one skid entry, so a new byte can be taken while a
// finished result still waits downstream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubx_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  ubx_pkg::result_t res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output ubx_pkg::result_t out_res
);
  import ubx_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Control: output register in front, skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: load only into an empty or draining slot
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (out_valid && !pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

endmodule
